// ===== sv/mipmapped_wavetable_oscillator_core_defines.svh =====
// assertion macros for the wavetable oscillator core
// no dependencies
`ifndef MIPMAPPED_WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH
`define MIPMAPPED_WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH
`define MWO_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MWO_ASSERT_NXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/mwo_pkg.sv =====
// shared codes and constants for the wavetable oscillator
// no dependencies
package mwo_pkg;
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_RENDER = 2'd1;
    localparam logic [1:0] ACT_PHASE  = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;
    localparam logic [1:0] REG_INC = 2'd0;
    localparam logic [1:0] REG_AMP = 2'd1;
    localparam logic [1:0] REG_MIPS = 2'd2;
    localparam logic [1:0] REG_LOAD = 2'd3;
    typedef struct packed {
        logic        start;
        logic [31:0] inc;
    } mip_req_t;
    typedef struct packed {
        logic        done;
        logic [16:0] pos;
    } mip_rsp_t;
endpackage

// ===== sv/mipmapped_wavetable_oscillator_core.sv =====
// top level of the mipmapped wavetable oscillator
// depends on mwo_pkg, mwo_mip_pos and the defines header
//
// input channel (valid/ready): action, mip_level, sample_index, sample_value, new_phase.
// output channel (valid/ready): audio_sample, phase_after, one transfer per render.
// write and set-phase items give no result.
// a render with no table loaded gives its result in the next cycle.
// with one mip level a render makes four reads from the single wave memory port, then
// interpolation, crossfade and gain steps, before its result is valid.
// with several levels the iterative mip position unit first does 12 squarings
// of a 32-bit mantissa.
// reset clears the phase, increment and load registers, sets the gain to 32768 and the mip
// count to 1; the wave memory stays undefined until written. if the receiver stalls, the
// result waits in the output register and the next item is taken once it has gone.
// apb: registers at 4*i, always ready, a read returns the value.
module mipmapped_wavetable_oscillator_core
    import mwo_pkg::*;
#(
    parameter int TABLE_BITS = 11,
    parameter int MAX_MIPS = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  mip_level,
    input  logic [10:0] sample_index,
    input  logic signed [15:0] sample_value,
    input  logic [31:0] new_phase,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] audio_sample,
    output logic [31:0] phase_after
);
`include "mipmapped_wavetable_oscillator_core_defines.svh"
    localparam int FB = 32 - TABLE_BITS;
    localparam int LB = (MAX_MIPS > 1) ? $clog2(MAX_MIPS) : 1;
    localparam int AW = LB + TABLE_BITS;
    localparam int SB = SAMPLE_BITS;

    localparam logic [3:0] S_IDLE = 4'd0, S_MIP = 4'd1, S_R0 = 4'd2, S_R1 = 4'd3,
        S_R2 = 4'd4, S_R3 = 4'd5, S_I0 = 4'd6, S_I1 = 4'd7, S_X = 4'd8,
        S_G = 4'd9, S_OUT = 4'd10;

    logic [31:0] inc_reg, phase_reg;
    logic [15:0] amp_reg;
    logic [4:0]  mips_reg;
    logic        load_reg;
    logic [3:0]  st_reg, st_next;
    logic [LB-1:0] l0_reg, l1_reg;
    logic [11:0] mix_reg;
    logic signed [SB-1:0] mem [0:(1<<AW)-1];
    logic signed [SB-1:0] rd_reg, y0a_reg, y1a_reg, y0b_reg;
    logic signed [SB:0]   va_reg, vb_reg, v_reg;
    logic signed [15:0] res_reg;
    logic [31:0] pa_reg;
    logic        ov_reg;
    logic        wr_en;
    logic [AW-1:0] waddr, raddr;
    logic [TABLE_BITS-1:0] i0, i1;
    mip_req_t mreq;
    mip_rsp_t mrsp;
    logic [4:0] n_eff;
    logic [16:0] top, posc;
    logic        acc;

    assign pready = 1'b1;
    assign acc = in_valid && in_ready;
    assign in_ready = (st_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INC:  prdata = inc_reg;
            REG_AMP:  prdata = {16'd0, amp_reg};
            REG_MIPS: prdata = {27'd0, mips_reg};
            REG_LOAD: prdata = {31'd0, load_reg};
            default:  prdata = 32'd0;
        endcase
    end

    assign mreq.start = acc && action == ACT_RENDER && load_reg && n_eff > 5'd1;
    assign mreq.inc = inc_reg;
    mwo_mip_pos #(.TABLE_BITS(TABLE_BITS)) u_mip (.clk(clk), .rst_n(rst_n), .req(mreq),
        .rsp(mrsp));

    always_comb
    begin
        n_eff = mips_reg;
        if (n_eff == 5'd0) n_eff = 5'd1;
        if (n_eff > 5'(MAX_MIPS)) n_eff = 5'(MAX_MIPS);
        top = {n_eff - 5'd1, 12'd0} - 17'd4;
        posc = (mrsp.pos > top) ? top : mrsp.pos;
    end

    assign i0 = phase_reg[31 -: TABLE_BITS];
    assign i1 = i0 + 1'b1;
    always_comb
    begin
        unique case (st_reg)
            S_R0:    raddr = {l0_reg, i0};
            S_R1:    raddr = {l0_reg, i1};
            S_R2:    raddr = {l1_reg, i0};
            default: raddr = {l1_reg, i1};
        endcase
    end

    assign wr_en = acc && action == ACT_WRITE && 32'(mip_level) < 32'(MAX_MIPS);
    assign waddr = {LB'(mip_level), TABLE_BITS'(sample_index)};
    always_ff @(posedge clk)
    begin
        if (wr_en) mem[waddr] <= SB'(sample_value);
        rd_reg <= mem[raddr];
    end

    // interpolation, crossfade and gain products
    logic signed [SB:0] da, db, dv;
    logic signed [SB+FB+1:0] pa, pb;
    logic signed [SB+13:0] px;
    logic signed [SB+17:0] pg;
    always_comb
    begin
        da = (SB+1)'(y1a_reg) - (SB+1)'(y0a_reg);
        db = (SB+1)'(rd_reg) - (SB+1)'(y0b_reg);
        pa = (SB+FB+2)'(da) * $signed({1'b0, phase_reg[FB-1:0]});
        pb = (SB+FB+2)'(db) * $signed({1'b0, phase_reg[FB-1:0]});
        dv = vb_reg - va_reg;
        px = (SB+14)'(dv) * $signed({1'b0, mix_reg});
        pg = (SB+18)'(v_reg) * $signed({1'b0, amp_reg});
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (acc && action == ACT_RENDER)
                st_next = !load_reg ? S_IDLE : (n_eff > 5'd1 ? S_MIP : S_R0);
            S_MIP:  if (mrsp.done) st_next = S_R0;
            S_R0:   st_next = S_R1;
            S_R1:   st_next = S_R2;
            S_R2:   st_next = S_R3;
            S_R3:   st_next = S_I0;
            S_I0:   st_next = S_I1;
            S_I1:   st_next = S_X;
            S_X:    st_next = S_G;
            S_G:    st_next = S_OUT;
            S_OUT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ov_reg <= 1'b0; phase_reg <= '0; inc_reg <= '0;
            amp_reg <= 16'd32768; mips_reg <= 5'd1; load_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_INC:  inc_reg <= pwdata;
                    REG_AMP:  amp_reg <= pwdata[15:0];
                    REG_MIPS: mips_reg <= pwdata[4:0];
                    default:  load_reg <= pwdata[0];
                endcase
            end
            if (acc && action == ACT_PHASE) phase_reg <= new_phase;
            if (st_reg == S_G) phase_reg <= phase_reg + inc_reg;
            if (out_valid && out_ready) ov_reg <= 1'b0;
            if ((acc && action == ACT_RENDER && !load_reg) || st_reg == S_OUT) ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && action == ACT_RENDER)
        begin
            l0_reg <= '0; l1_reg <= '0; mix_reg <= '0;
            res_reg <= '0; pa_reg <= phase_reg;
        end
        if (st_reg == S_MIP && mrsp.done)
        begin
            l0_reg <= LB'(posc[16:12]); l1_reg <= LB'(posc[16:12] + 5'd1);
            mix_reg <= posc[11:0];
        end
        if (st_reg == S_R1) y0a_reg <= rd_reg;
        if (st_reg == S_R2) y1a_reg <= rd_reg;
        if (st_reg == S_R3) y0b_reg <= rd_reg;
        if (st_reg == S_I0) va_reg <= (SB+1)'(y0a_reg) + (SB+1)'(pa >>> FB);
        if (st_reg == S_I0) vb_reg <= (SB+1)'(y0b_reg) + (SB+1)'(pb >>> FB);
        if (st_reg == S_X) v_reg <= va_reg + (SB+1)'(px >>> 12);
        if (st_reg == S_G)
        begin
            if (pg >>> 15 > 32767) res_reg <= 16'sd32767;
            else if (pg >>> 15 < -32768) res_reg <= -16'sd32768;
            else res_reg <= 16'(pg >>> 15);
            pa_reg <= phase_reg + inc_reg;
        end
    end

    assign out_valid = ov_reg;
    assign audio_sample = res_reg;
    assign phase_after = pa_reg;

    `MWO_ASSERT_IMP(a_busy_no_ready, st_reg != S_IDLE, !in_ready, "ready while busy")
    `MWO_ASSERT_NXT(a_out_after_g, st_reg == S_OUT, out_valid, "result lost")
    `MWO_ASSERT_IMP(a_mip_only_wait, mrsp.done, st_reg == S_MIP, "mip result unexpected")
endmodule

// ===== sv/mwo_mip_pos.sv =====
// iterative log2 of the phase increment, 12 fraction bits by squaring
// depends on mwo_pkg
module mwo_mip_pos
    import mwo_pkg::*;
#(
    parameter int TABLE_BITS = 11
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mip_req_t req,
    output mip_rsp_t rsp
);
    localparam int FB = 32 - TABLE_BITS;
    logic [31:0] m_reg, m_next;
    logic [11:0] frac_reg, frac_next;
    logic [4:0]  p_reg, p_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, zero_reg, zero_next, done_reg, done_next;
    logic [63:0] sq;
    logic [4:0]  msb;
    logic [4:0]  ip;

    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
            if (req.inc[i]) msb = 5'(i);
    end

    assign sq = {32'd0, m_reg} * {32'd0, m_reg};

    always_comb
    begin
        m_next = m_reg; frac_next = frac_reg; p_next = p_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; zero_next = zero_reg; done_next = 1'b0;
        if (req.start)
        begin
            m_next = req.inc << (5'd31 - msb);
            p_next = msb; cnt_next = 4'd0; frac_next = 12'd0; busy_next = 1'b1;
            zero_next = (req.inc < (32'd1 << FB));
        end
        else if (busy_reg)
        begin
            frac_next = {frac_reg[10:0], sq[63]};
            m_next = sq[63] ? sq[63:32] : sq[62:31];
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd11)
            begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next; frac_reg <= frac_next; p_reg <= p_next; zero_reg <= zero_next;
    end

    assign ip = p_reg - 5'(FB);
    assign rsp.done = done_reg;
    assign rsp.pos = zero_reg ? 17'd0 : {ip, frac_reg};
endmodule
